### rtl/rap_pkg.sv
// Shared types and constants for the router advertisement parser.
package rap_pkg;

	// Default number of DNS servers kept per packet.
	localparam int MAX_DNS_DEF = 3;
	// Number of DNS servers reported in a run.
	localparam int DNS_REPORT_MAX = 3;

	// Header layout and match values.
	localparam logic [15:0] OPT_START   = 16'd56;
	localparam logic [15:0] MIN_LENGTH  = 16'd56;
	localparam logic [15:0] IDX_NEXT_HDR = 16'd6;
	localparam logic [15:0] IDX_ICMP_TYPE = 16'd40;
	localparam logic [15:0] IDX_CUR_HOP = 16'd44;
	localparam logic [15:0] IDX_FLAGS   = 16'd45;
	localparam logic [15:0] IDX_LIFE_HI = 16'd46;
	localparam logic [15:0] IDX_LIFE_LO = 16'd47;
	localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
	localparam logic [3:0]  IP_VERSION  = 4'd6;
	localparam logic [7:0]  NH_ICMPV6   = 8'd58;
	localparam logic [7:0]  ICMP_RA     = 8'd134;
	localparam logic [7:0]  FLAG_M      = 8'h80;
	localparam logic [7:0]  FLAG_O      = 8'h40;

	// NDP option types.
	localparam logic [7:0] OPT_PREFIX = 8'd3;
	localparam logic [7:0] OPT_MTU    = 8'd5;
	localparam logic [7:0] OPT_RDNSS  = 8'd25;

	// Record kinds of an output run.
	typedef enum logic [2:0] {
		REC_LIFETIME,
		REC_MTU,
		REC_GW_HI,
		REC_GW_LO,
		REC_PFX_HI,
		REC_PFX_LO,
		REC_DNS_HI,
		REC_DNS_LO
	} rec_kind_t;

	// Everything the output run needs from one finished packet.
	typedef struct packed {
		logic        valid;
		logic        gw;
		logic        pdone;
		logic [7:0]  hop;
		logic        mflag;
		logic        oflag;
		logic [7:0]  plen;
		logic [1:0]  dns_cnt;
		logic [1:0]  dns_run;
		logic [31:0] mtu;
		logic [2:0][63:0] pfx;
		logic [1:0][63:0] src;
		logic [2*DNS_REPORT_MAX-1:0][63:0] dns;
	} rap_summary_t;

endpackage

### rtl/rap_parser.sv
// Per-byte header check, field capture and NDP option walk.
module rap_parser import rap_pkg::*; #(
	parameter int MAX_DNS = MAX_DNS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         take,
	input  logic [7:0]   data_byte,
	input  logic         last_byte,
	output rap_summary_t summary
);

	localparam int CW = $clog2(MAX_DNS + 1);
	localparam int SLOTS = 2 * MAX_DNS;

	logic [15:0] cnt_q, cnt_n, nos_q, nos_n;
	logic        hv_q, hv_n, m_q, m_n, o_q, o_n, lt_q, lt_n, stop_q, stop_n;
	logic [7:0]  hop_q, hop_n, otype_q, otype_n, olen_q, olen_n;
	logic [1:0][63:0] src_q, src_n;
	logic [2:0][63:0] ppfx_q, ppfx_n, cpfx_q, cpfx_n;
	logic [7:0]  pplen_q, pplen_n, cplen_q, cplen_n;
	logic [31:0] pmtu_q, pmtu_n, cmtu_q, cmtu_n;
	logic        pdone_q, pdone_n;
	logic [SLOTS-1:0][63:0] pdns_q, pdns_n, dstore_q, dstore_n;
	logic [CW-1:0] dcnt_q, dcnt_n;

	logic        active;
	logic [15:0] rel, off, slot;
	logic [10:0] len8;
	logic [8:0]  dsum, dcap;
	logic [1:0]  nd;

	// Next state for one accepted byte.
	always_comb begin
		cnt_n = cnt_q; nos_n = nos_q; hv_n = hv_q; m_n = m_q; o_n = o_q;
		lt_n = lt_q; stop_n = stop_q; hop_n = hop_q; otype_n = otype_q;
		olen_n = olen_q; src_n = src_q; ppfx_n = ppfx_q; cpfx_n = cpfx_q;
		pplen_n = pplen_q; cplen_n = cplen_q; pmtu_n = pmtu_q; cmtu_n = cmtu_q;
		pdone_n = pdone_q; pdns_n = pdns_q; dstore_n = dstore_q; dcnt_n = dcnt_q;
		rel = cnt_q - nos_q;
		off = rel - 16'd8;
		slot = 16'(dcnt_q) + {4'b0, off[15:4]};
		len8 = {olen_q, 3'b000};
		dsum = 9'(dcnt_q) + 9'((olen_q - 8'd1) >> 1);
		dcap = (dsum > 9'(MAX_DNS)) ? 9'(MAX_DNS) : dsum;
		active = take && (cnt_q != COUNT_MAX);
		if (active) begin
			// Fixed header fields.
			if (cnt_q == 16'd0 && data_byte[7:4] != IP_VERSION) hv_n = 1'b0;
			if (cnt_q == IDX_NEXT_HDR && data_byte != NH_ICMPV6) hv_n = 1'b0;
			if (cnt_q == IDX_ICMP_TYPE && data_byte != ICMP_RA) hv_n = 1'b0;
			if (cnt_q >= 16'd8 && cnt_q < 16'd16) src_n[0] = {src_q[0][55:0], data_byte};
			if (cnt_q >= 16'd16 && cnt_q < 16'd24) src_n[1] = {src_q[1][55:0], data_byte};
			if (cnt_q == IDX_CUR_HOP) hop_n = data_byte;
			if (cnt_q == IDX_FLAGS) begin
				m_n = (data_byte & FLAG_M) != 8'd0;
				o_n = (data_byte & FLAG_O) != 8'd0;
			end
			if ((cnt_q == IDX_LIFE_HI || cnt_q == IDX_LIFE_LO) && data_byte != 8'd0)
				lt_n = 1'b1;
			// Option walk.
			if (!stop_q && cnt_q >= nos_q) begin
				if (rel == 16'd0) begin
					otype_n = data_byte;
					olen_n = 8'd0;
				end else if (rel == 16'd1) begin
					olen_n = data_byte;
					if (data_byte == 8'd0 ||
					    ({1'b0, nos_q} + {6'b0, data_byte, 3'b000}) > 17'h0FFFF)
						stop_n = 1'b1;
				end else begin
					if (otype_q == OPT_PREFIX) begin
						if (rel == 16'd2) pplen_n = data_byte;
						else if (rel >= 16'd4 && rel < 16'd12)
							ppfx_n[0] = {ppfx_q[0][55:0], data_byte};
						else if (rel >= 16'd16 && rel < 16'd24)
							ppfx_n[1] = {ppfx_q[1][55:0], data_byte};
						else if (rel >= 16'd24 && rel < 16'd32)
							ppfx_n[2] = {ppfx_q[2][55:0], data_byte};
					end else if (otype_q == OPT_MTU) begin
						if (rel >= 16'd4 && rel < 16'd8) pmtu_n = {pmtu_q[23:0], data_byte};
					end else if (otype_q == OPT_RDNSS) begin
						if (rel >= 16'd8) begin
							for (int s = 0; s < MAX_DNS; s++) begin
								if (slot == 16'(s) && !off[3])
									pdns_n[2*s] = {pdns_q[2*s][55:0], data_byte};
								if (slot == 16'(s) && off[3])
									pdns_n[2*s+1] = {pdns_q[2*s+1][55:0], data_byte};
							end
						end
					end
					// Commit on the option's final byte.
					if (rel == 16'(len8) - 16'd1) begin
						nos_n = nos_q + 16'(len8);
						if (otype_q == OPT_PREFIX) begin
							if (olen_q == 8'd4 && !pdone_q) begin
								cpfx_n = ppfx_n;
								cplen_n = pplen_n;
								pdone_n = 1'b1;
							end
						end else if (otype_q == OPT_MTU) begin
							if (olen_q == 8'd1) cmtu_n = pmtu_n;
						end else if (otype_q == OPT_RDNSS) begin
							if (olen_q >= 8'd3 && dcnt_q < CW'(MAX_DNS)) begin
								for (int i = 0; i < MAX_DNS; i++) begin
									if (9'(i) >= 9'(dcnt_q) && 9'(i) < dcap) begin
										dstore_n[2*i] = pdns_n[2*i];
										dstore_n[2*i+1] = pdns_n[2*i+1];
									end
								end
								dcnt_n = CW'(dcap);
							end
						end
					end
				end
			end
			cnt_n = cnt_q + 16'd1;
		end
	end

	// Summary of the packet including the current byte. The reported count
	// is the stored count masked to two bits; the run length is capped.
	always_comb begin
		nd = (dcnt_n > CW'(DNS_REPORT_MAX)) ? 2'(DNS_REPORT_MAX) : 2'(dcnt_n);
		summary.valid = hv_n && (cnt_n >= MIN_LENGTH);
		summary.gw = lt_n;
		summary.pdone = pdone_n;
		summary.hop = hop_n;
		summary.mflag = m_n;
		summary.oflag = o_n;
		summary.plen = cplen_n;
		summary.dns_cnt = 2'(dcnt_n);
		summary.dns_run = nd;
		summary.mtu = cmtu_n;
		summary.pfx = cpfx_n;
		summary.src = src_n;
		for (int d = 0; d < 2 * DNS_REPORT_MAX; d++) begin
			summary.dns[d] = (d < SLOTS) ? dstore_n[(d < SLOTS) ? d : 0] : 64'd0;
		end
	end

	// Control and header state; a packet end returns it to reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 16'd0; nos_q <= OPT_START; hv_q <= 1'b1; m_q <= 1'b0; o_q <= 1'b0;
			lt_q <= 1'b0; stop_q <= 1'b0; hop_q <= 8'd0; otype_q <= 8'd0; olen_q <= 8'd0;
			src_q <= '0; ppfx_q <= '0; cpfx_q <= '0; pplen_q <= 8'd0; cplen_q <= 8'd0;
			pmtu_q <= 32'd0; cmtu_q <= 32'd0; pdone_q <= 1'b0; dcnt_q <= '0;
		end else if (take && last_byte) begin
			cnt_q <= 16'd0; nos_q <= OPT_START; hv_q <= 1'b1; m_q <= 1'b0; o_q <= 1'b0;
			lt_q <= 1'b0; stop_q <= 1'b0; hop_q <= 8'd0; otype_q <= 8'd0; olen_q <= 8'd0;
			src_q <= '0; ppfx_q <= '0; cpfx_q <= '0; pplen_q <= 8'd0; cplen_q <= 8'd0;
			pmtu_q <= 32'd0; cmtu_q <= 32'd0; pdone_q <= 1'b0; dcnt_q <= '0;
		end else begin
			cnt_q <= cnt_n; nos_q <= nos_n; hv_q <= hv_n; m_q <= m_n; o_q <= o_n;
			lt_q <= lt_n; stop_q <= stop_n; hop_q <= hop_n; otype_q <= otype_n;
			olen_q <= olen_n; src_q <= src_n; ppfx_q <= ppfx_n; cpfx_q <= cpfx_n;
			pplen_q <= pplen_n; cplen_q <= cplen_n; pmtu_q <= pmtu_n; cmtu_q <= cmtu_n;
			pdone_q <= pdone_n; dcnt_q <= dcnt_n;
		end
	end

	// DNS buffers are only read after they are written.
	always_ff @(posedge clk) begin
		pdns_q <= pdns_n;
		dstore_q <= dstore_n;
	end

	// The count restarts after every packet end.
	a_cnt_restart: assert property (@(posedge clk) disable iff (!arst_n)
		take && last_byte |=> cnt_q == 16'd0)
		else $error("byte count not cleared after packet end");

	// The stored server count never exceeds its limit.
	a_dcnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		dcnt_q <= CW'(MAX_DNS))
		else $error("dns count above limit");

	// A saturated count leaves the option walk untouched.
	a_sat_hold: assert property (@(posedge clk) disable iff (!arst_n)
		take && !last_byte && cnt_q == COUNT_MAX |=> $stable(nos_q) && $stable(stop_q))
		else $error("option state changed on saturated count");

endmodule

### rtl/router_advert_parser.sv
// Top level: byte parser plus output run sequencer for router advertisements.
//
//   channel  direction  handshake              payload
//   input    in         in_valid / in_stall    data_byte, last_byte
//   output   out        out_valid / out_stall  record_kind ... dns_total
//
// One packet byte is accepted per cycle while in_stall is low; its header and option
// work is done in the same cycle by the parser. The byte marked last copies the packet
// summary into a run register and the parser starts the next packet at once.
// A run has 1 to 12 records, one record per cycle while out_stall is low.
// Only a last byte is stalled, and only while the previous run is still draining.
// Reset clears all control state; the DNS buffers need no reset.
module router_advert_parser import rap_pkg::*; #(
	parameter int MAX_DNS = MAX_DNS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  record_kind,
	output logic [1:0]  dns_index,
	output logic [63:0] record_word,
	output logic        run_end,
	output logic        accepted,
	output logic [7:0]  hop_lim,
	output logic        m_bit,
	output logic        o_bit,
	output logic        gw_seen,
	output logic        pfx_seen,
	output logic [7:0]  pfx_len,
	output logic [1:0]  dns_total
);

	rap_summary_t summary, snap_q;
	logic         busy_q, take, load, finish, last_rec;
	rec_kind_t    kind_q, kind_nx;
	logic [1:0]   didx_q, didx_nx;

	rap_parser #(.MAX_DNS(MAX_DNS)) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.summary   (summary)
	);

	// Next record of the run and whether the current one ends it.
	always_comb begin
		kind_nx = kind_q;
		didx_nx = didx_q;
		last_rec = 1'b0;
		unique case (kind_q)
			REC_LIFETIME: kind_nx = REC_MTU;
			REC_MTU: begin
				if (snap_q.gw) kind_nx = REC_GW_HI;
				else if (snap_q.pdone) kind_nx = REC_PFX_HI;
				else if (snap_q.dns_run != 2'd0) kind_nx = REC_DNS_HI;
				else last_rec = 1'b1;
			end
			REC_GW_HI: kind_nx = REC_GW_LO;
			REC_GW_LO: begin
				if (snap_q.pdone) kind_nx = REC_PFX_HI;
				else if (snap_q.dns_run != 2'd0) kind_nx = REC_DNS_HI;
				else last_rec = 1'b1;
			end
			REC_PFX_HI: kind_nx = REC_PFX_LO;
			REC_PFX_LO: begin
				if (snap_q.dns_run != 2'd0) kind_nx = REC_DNS_HI;
				else last_rec = 1'b1;
			end
			REC_DNS_HI: kind_nx = REC_DNS_LO;
			REC_DNS_LO: begin
				if (didx_q + 2'd1 < snap_q.dns_run) begin
					kind_nx = REC_DNS_HI;
					didx_nx = didx_q + 2'd1;
				end else begin
					last_rec = 1'b1;
				end
			end
			default: last_rec = 1'b1;
		endcase
		if (!snap_q.valid) last_rec = 1'b1;
	end

	// Handshakes.
	assign out_valid = busy_q;
	assign run_end = last_rec;
	assign finish = busy_q && !out_stall && last_rec;
	assign in_stall = last_byte && busy_q && !finish;
	assign take = in_valid && !in_stall;
	assign load = take && last_byte;

	// Run register and record pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			kind_q <= REC_LIFETIME;
			didx_q <= 2'd0;
		end else if (load) begin
			busy_q <= 1'b1;
			kind_q <= REC_LIFETIME;
			didx_q <= 2'd0;
		end else if (busy_q && !out_stall) begin
			if (last_rec) begin
				busy_q <= 1'b0;
			end else begin
				kind_q <= kind_nx;
				didx_q <= didx_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) snap_q <= summary;
	end

	// Record payload and repeated packet summary.
	always_comb begin
		record_kind = 3'(kind_q);
		dns_index = (kind_q == REC_DNS_HI || kind_q == REC_DNS_LO) ? didx_q : 2'd0;
		unique case (kind_q)
			REC_LIFETIME: record_word = snap_q.pdone ? snap_q.pfx[0] : 64'd0;
			REC_MTU:      record_word = {32'd0, snap_q.mtu};
			REC_GW_HI:    record_word = snap_q.src[0];
			REC_GW_LO:    record_word = snap_q.src[1];
			REC_PFX_HI:   record_word = snap_q.pfx[1];
			REC_PFX_LO:   record_word = snap_q.pfx[2];
			REC_DNS_HI:   record_word = snap_q.dns[{didx_q, 1'b0}];
			REC_DNS_LO:   record_word = snap_q.dns[{didx_q, 1'b1}];
			default:      record_word = 64'd0;
		endcase
		accepted = snap_q.gw || snap_q.pdone;
		hop_lim = snap_q.hop;
		m_bit = snap_q.mflag;
		o_bit = snap_q.oflag;
		gw_seen = snap_q.gw;
		pfx_seen = snap_q.pdone;
		pfx_len = snap_q.plen;
		dns_total = snap_q.dns_cnt;
		// A rejected or short packet gives one all-zero record.
		if (!snap_q.valid) begin
			record_kind = 3'd0;
			dns_index = 2'd0;
			record_word = 64'd0;
			accepted = 1'b0;
			hop_lim = 8'd0;
			m_bit = 1'b0;
			o_bit = 1'b0;
			gw_seen = 1'b0;
			pfx_seen = 1'b0;
			pfx_len = 8'd0;
			dns_total = 2'd0;
		end
	end

	// A new run never overwrites one that is still draining.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !busy_q || finish)
		else $error("run overwritten before its last record");

	// A DNS record always refers to a stored server.
	a_dns_index: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && snap_q.valid && (kind_q == REC_DNS_HI || kind_q == REC_DNS_LO)
		|-> didx_q < snap_q.dns_run)
		else $error("dns record beyond stored count");

	// Every run starts with the lifetimes record.
	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> busy_q && kind_q == REC_LIFETIME && didx_q == 2'd0)
		else $error("run did not start at lifetimes record");

endmodule

### sim/tb.sv
// Self-checking testbench for the router advertisement parser, with its own packet predictor.
module tb;
	import rap_pkg::*;

	localparam int DNS_SLOTS = MAX_DNS_DEF;
	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 400;

	// One output record as the parser should present it.
	typedef struct {
		logic [2:0]  kind;
		logic [1:0]  idx;
		logic [63:0] word;
		logic        fin;
		logic        acc;
		logic [7:0]  hop;
		logic        mflag;
		logic        oflag;
		logic        gw;
		logic        pfx;
		logic [7:0]  plen;
		logic [1:0]  dcnt;
	} ra_record_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = '0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  record_kind;
	logic [1:0]  dns_index;
	logic [63:0] record_word;
	logic        run_end;
	logic        accepted;
	logic [7:0]  hop_lim;
	logic        m_bit;
	logic        o_bit;
	logic        gw_seen;
	logic        pfx_seen;
	logic [7:0]  pfx_len;
	logic [1:0]  dns_total;

	router_advert_parser dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Predicted parser state.
	int          byte_cnt;
	bit          hdr_ok;
	logic [63:0] src_addr [2];
	logic [7:0]  cur_hop;
	logic        cur_m, cur_o, life_nz;
	int          opt_start;
	logic [15:0] opt_tl;
	bit          opt_stop;
	logic [63:0] pend_pfx [3];
	logic [7:0]  pend_plen;
	logic [31:0] pend_mtu;
	logic [63:0] pend_dns [2*DNS_SLOTS];
	logic [63:0] kept_pfx [3];
	logic [7:0]  kept_plen;
	logic [31:0] kept_mtu;
	bit          pfx_kept;
	logic [63:0] kept_dns [2*DNS_SLOTS];
	int          kept_dns_cnt;

	ra_record_t  expected_records [$];
	logic [7:0]  pkt [$];

	int errors = 0;
	int cycle = 0;
	int bytes_sent = 0;
	int packets_sent = 0;
	int records_predicted = 0;
	int records_seen = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_until = 0;

	function automatic void clear_parser();
		byte_cnt = 0;
		hdr_ok = 1'b1;
		src_addr = '{default: '0};
		cur_hop = '0;
		cur_m = 1'b0;
		cur_o = 1'b0;
		life_nz = 1'b0;
		opt_start = int'(OPT_START);
		opt_tl = '0;
		opt_stop = 1'b0;
		pend_pfx = '{default: '0};
		pend_plen = '0;
		pend_mtu = '0;
		pend_dns = '{default: '0};
		kept_pfx = '{default: '0};
		kept_plen = '0;
		kept_mtu = '0;
		pfx_kept = 1'b0;
		kept_dns = '{default: '0};
		kept_dns_cnt = 0;
	endfunction

	// Apply a completed option to the kept values.
	function automatic void commit_option(logic [7:0] ty, logic [7:0] ln);
		int n;
		if (ty == OPT_PREFIX) begin
			if (ln == 8'd4 && !pfx_kept) begin
				kept_pfx = pend_pfx;
				kept_plen = pend_plen;
				pfx_kept = 1'b1;
			end
		end else if (ty == OPT_MTU) begin
			if (ln == 8'd1)
				kept_mtu = pend_mtu;
		end else if (ty == OPT_RDNSS) begin
			if (ln >= 8'd3 && kept_dns_cnt < DNS_SLOTS) begin
				n = kept_dns_cnt + (int'(ln) - 1) / 2;
				if (n > DNS_SLOTS)
					n = DNS_SLOTS;
				for (int i = kept_dns_cnt; i < n; i++) begin
					kept_dns[2*i] = pend_dns[2*i];
					kept_dns[2*i+1] = pend_dns[2*i+1];
				end
				kept_dns_cnt = n;
			end
		end
	endfunction

	function automatic void push_record(logic [2:0] kind, int idx, logic [63:0] word, logic acc);
		ra_record_t r;
		r.kind = kind;
		r.idx = idx[1:0];
		r.word = word;
		r.fin = 1'b0;
		r.acc = acc;
		r.hop = cur_hop;
		r.mflag = cur_m;
		r.oflag = cur_o;
		r.gw = life_nz;
		r.pfx = pfx_kept;
		r.plen = kept_plen;
		r.dcnt = kept_dns_cnt[1:0];
		expected_records.push_back(r);
		records_predicted++;
	endfunction

	// Predict the effect of one accepted packet byte.
	function automatic void parse_advert_byte(logic [7:0] b, logic last);
		int rel, slot, k, nd;
		logic [7:0] ty, ln;
		logic acc;
		ra_record_t z;
		if (byte_cnt < int'(COUNT_MAX)) begin
			if (byte_cnt == 0 && b[7:4] != IP_VERSION)
				hdr_ok = 1'b0;
			if (byte_cnt == int'(IDX_NEXT_HDR) && b != NH_ICMPV6)
				hdr_ok = 1'b0;
			if (byte_cnt == int'(IDX_ICMP_TYPE) && b != ICMP_RA)
				hdr_ok = 1'b0;
			if (byte_cnt >= 8 && byte_cnt < 16)
				src_addr[0] = {src_addr[0][55:0], b};
			if (byte_cnt >= 16 && byte_cnt < 24)
				src_addr[1] = {src_addr[1][55:0], b};
			if (byte_cnt == int'(IDX_CUR_HOP))
				cur_hop = b;
			if (byte_cnt == int'(IDX_FLAGS)) begin
				cur_m = |(b & FLAG_M);
				cur_o = |(b & FLAG_O);
			end
			if ((byte_cnt == int'(IDX_LIFE_HI) || byte_cnt == int'(IDX_LIFE_LO)) && b != 8'd0)
				life_nz = 1'b1;
			// Option walk.
			if (!opt_stop && byte_cnt >= opt_start) begin
				rel = byte_cnt - opt_start;
				if (rel == 0) begin
					opt_tl = {b, 8'h00};
				end else if (rel == 1) begin
					opt_tl[7:0] = b;
					if (b == 8'd0 || opt_start + int'(b) * 8 > 65535)
						opt_stop = 1'b1;
				end else begin
					ty = opt_tl[15:8];
					ln = opt_tl[7:0];
					if (ty == OPT_PREFIX) begin
						if (rel == 2)
							pend_plen = b;
						else if (rel >= 4 && rel < 12)
							pend_pfx[0] = {pend_pfx[0][55:0], b};
						else if (rel >= 16 && rel < 24)
							pend_pfx[1] = {pend_pfx[1][55:0], b};
						else if (rel >= 24 && rel < 32)
							pend_pfx[2] = {pend_pfx[2][55:0], b};
					end else if (ty == OPT_MTU) begin
						if (rel >= 4 && rel < 8)
							pend_mtu = {pend_mtu[23:0], b};
					end else if (ty == OPT_RDNSS) begin
						if (rel >= 8) begin
							slot = kept_dns_cnt + (rel - 8) / 16;
							k = 2 * slot + ((rel - 8) % 16) / 8;
							if (slot < DNS_SLOTS)
								pend_dns[k] = {pend_dns[k][55:0], b};
						end
					end
					if (rel == int'(ln) * 8 - 1) begin
						commit_option(ty, ln);
						opt_start += int'(ln) * 8;
					end
				end
			end
			byte_cnt++;
		end
		if (!last)
			return;
		// Build the run for the finished packet.
		if (!hdr_ok || byte_cnt < int'(MIN_LENGTH)) begin
			z = '{kind: REC_LIFETIME, idx: '0, word: '0, fin: 1'b1, acc: 1'b0, hop: '0,
				mflag: 1'b0, oflag: 1'b0, gw: 1'b0, pfx: 1'b0, plen: '0, dcnt: '0};
			expected_records.push_back(z);
			records_predicted++;
		end else begin
			acc = life_nz | pfx_kept;
			nd = kept_dns_cnt < DNS_REPORT_MAX ? kept_dns_cnt : DNS_REPORT_MAX;
			push_record(REC_LIFETIME, 0, pfx_kept ? kept_pfx[0] : 64'd0, acc);
			push_record(REC_MTU, 0, {32'd0, kept_mtu}, acc);
			if (life_nz) begin
				push_record(REC_GW_HI, 0, src_addr[0], acc);
				push_record(REC_GW_LO, 0, src_addr[1], acc);
			end
			if (pfx_kept) begin
				push_record(REC_PFX_HI, 0, kept_pfx[1], acc);
				push_record(REC_PFX_LO, 0, kept_pfx[2], acc);
			end
			for (int d = 0; d < nd; d++) begin
				push_record(REC_DNS_HI, d, kept_dns[2*d], acc);
				push_record(REC_DNS_LO, d, kept_dns[2*d+1], acc);
			end
			expected_records[$].fin = 1'b1;
		end
		clear_parser();
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch at cycle %0d: %s got %h expected %h", cycle, what, got, want);
		errors++;
	endtask

	// Input monitor: a transaction seen before the edge is taken at that edge.
	always @(negedge clk) begin
		if (arst_n && in_valid && !in_stall)
			parse_advert_byte(data_byte, last_byte);
	end

	// Output checker against the oldest expected record.
	always @(negedge clk) begin
		ra_record_t e;
		if (arst_n && out_valid && !out_stall) begin
			records_seen++;
			if (expected_records.size() == 0) begin
				report_mismatch("unexpected record, kind", record_kind, '0);
			end else begin
				e = expected_records.pop_front();
				if (record_kind !== e.kind) report_mismatch("record_kind", record_kind, e.kind);
				if (dns_index !== e.idx) report_mismatch("dns_index", dns_index, e.idx);
				if (record_word !== e.word) report_mismatch("record_word", record_word, e.word);
				if (run_end !== e.fin) report_mismatch("run_end", run_end, e.fin);
				if (accepted !== e.acc) report_mismatch("accepted", accepted, e.acc);
				if (hop_lim !== e.hop) report_mismatch("hop_lim", hop_lim, e.hop);
				if (m_bit !== e.mflag) report_mismatch("m_bit", m_bit, e.mflag);
				if (o_bit !== e.oflag) report_mismatch("o_bit", o_bit, e.oflag);
				if (gw_seen !== e.gw) report_mismatch("gw_seen", gw_seen, e.gw);
				if (pfx_seen !== e.pfx) report_mismatch("pfx_seen", pfx_seen, e.pfx);
				if (pfx_len !== e.plen) report_mismatch("pfx_len", pfx_len, e.plen);
				if (dns_total !== e.dcnt) report_mismatch("dns_total", dns_total, e.dcnt);
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off when one is requested.
	always @(posedge clk) begin
		out_stall <= (cycle < hold_until) || ($urandom_range(99) < recv_stall_pct);
	end

	// Cycle count and run timeout.
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d records still expected", cycle,
				expected_records.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Offer one byte and hold it until the parser takes it.
	task automatic send_byte(logic [7:0] b, logic last);
		bit took;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= last;
		do begin
			@(negedge clk);
			took = !in_stall;
			@(posedge clk);
		end while (!took);
		bytes_sent++;
	endtask

	task automatic send_packet();
		for (int i = 0; i < pkt.size(); i++)
			send_byte(pkt[i], i == pkt.size() - 1);
		packets_sent++;
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (expected_records.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Sender idle and receiver stall rates for the tests that follow.
	task automatic set_phase(int idle, int stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
	endtask

	// IPv6 plus RA header, 56 bytes, with a well-formed version, next header and type.
	task automatic put_header(logic [7:0] hop, logic [7:0] flags, bit life);
		pkt.delete();
		pkt.push_back({IP_VERSION, 4'($urandom)});
		for (int i = 1; i < 56; i++)
			pkt.push_back(8'($urandom));
		pkt[IDX_NEXT_HDR] = NH_ICMPV6;
		pkt[IDX_ICMP_TYPE] = ICMP_RA;
		pkt[IDX_CUR_HOP] = hop;
		pkt[IDX_FLAGS] = flags;
		pkt[IDX_LIFE_HI] = life ? 8'($urandom) : 8'd0;
		pkt[IDX_LIFE_LO] = life ? 8'($urandom_range(1, 255)) : 8'd0;
	endtask

	// Append an option with random body; a zero length gets two stray bytes.
	task automatic add_opt(logic [7:0] ty, logic [7:0] ln);
		int body;
		body = (ln == 8'd0) ? 2 : int'(ln) * 8 - 2;
		pkt.push_back(ty);
		pkt.push_back(ln);
		for (int i = 0; i < body; i++)
			pkt.push_back(8'($urandom));
	endtask

	task automatic test_header_checks();
		// One full-length packet with one of the three header checks broken.
		put_header(8'd64, 8'h00, 1'b1);
		case ($urandom_range(2))
			0: pkt[0] = 8'h45;
			1: pkt[IDX_NEXT_HDR] = 8'd17;
			default: pkt[IDX_ICMP_TYPE] = 8'd133;
		endcase
		send_packet();
		wait_drain();
	endtask

	task automatic test_short_packets();
		pkt = '{8'h00};
		send_packet();
		pkt = '{8'hFF};
		send_packet();
		wait_drain();
	endtask

	task automatic test_option_walk();
		// Prefix and MTU kept, DNS servers cap at the slot count, then a zero
		// option length stops the walk.
		put_header(8'd255, 8'hC0, 1'b0);
		add_opt(OPT_PREFIX, 8'd4);
		add_opt(OPT_MTU, 8'd1);
		add_opt(OPT_RDNSS, 8'd5);
		add_opt(OPT_RDNSS, 8'd5);
		add_opt(OPT_MTU, 8'd0);
		send_packet();
		wait_drain();
	endtask

	task automatic test_pressure();
		// Receiver holds off while short packets keep arriving.
		hold_until = cycle + HOLD_CYCLES;
		for (int i = 0; i < 16; i++) begin
			pkt = '{8'($urandom)};
			send_packet();
		end
		wait_drain();
	endtask

	task automatic make_random_packet();
		int c, r;
		r = $urandom_range(99);
		put_header(8'($urandom), 8'($urandom), 1'($urandom_range(1)));
		if (r < 4) pkt[0] = 8'($urandom);
		else if (r < 8) pkt[IDX_NEXT_HDR] = 8'($urandom);
		else if (r < 11) pkt[IDX_ICMP_TYPE] = 8'($urandom);
		repeat ($urandom_range(2)) begin
			c = $urandom_range(9);
			case (c)
				0: add_opt(OPT_PREFIX, 8'($urandom_range(1, 6)));
				1, 2: add_opt(OPT_PREFIX, 8'd4);
				3: add_opt(OPT_MTU, 8'd1);
				4: add_opt(OPT_MTU, 8'($urandom_range(1, 3)));
				5, 6, 7: add_opt(OPT_RDNSS, 8'($urandom_range(1, 7)));
				8: add_opt(8'($urandom), 8'($urandom_range(1, 3)));
				default: add_opt(8'($urandom), 8'($urandom_range(0, 2)));
			endcase
		end
		repeat ($urandom_range(3)) pkt.push_back(8'($urandom));
		if ($urandom_range(9) == 0)
			pkt = pkt[0:$urandom_range(pkt.size() - 1)];
	endtask

	task automatic test_random_traffic();
		int b0;
		b0 = bytes_sent;
		while (bytes_sent - b0 < 40) begin
			make_random_packet();
			send_packet();
		end
		wait_drain();
	endtask

	initial begin
		clear_parser();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_phase(0, 0);
		test_header_checks();
		test_short_packets();
		set_phase(81, 0);
		test_option_walk();
		set_phase(0, 81);
		test_pressure();
		set_phase(25, 25);
		test_random_traffic();
		set_phase(0, 0);
		repeat (20) @(posedge clk);
		$display("Sent %0d packets (%0d bytes), predicted %0d and checked %0d records,",
			packets_sent, bytes_sent, records_predicted, records_seen);
		$display("covering header rejects, short packets, option walks and backpressure.");
		if (errors == 0 && expected_records.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches, %0d records never arrived", errors,
				expected_records.size());
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

### filelist.f
rtl/rap_pkg.sv
rtl/rap_parser.sv
rtl/router_advert_parser.sv
sim/tb.sv
